// File: sv/linear_regression_fit_defines.svh
// ============================================================================
// Linear regression fit - assertion macros
// Shared property wrappers used by the modules of the line-fit block.
// ============================================================================
`ifndef LINEAR_REGRESSION_FIT_DEFINES_SVH
`define LINEAR_REGRESSION_FIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LRF_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LRF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lrf_pkg.sv
// ============================================================================
// Linear regression fit - package
// Sizes, payload types, status codes and sequencer encodings of the block.
// ============================================================================
package lrf_pkg;

    // Data set limits and number formats
    localparam int MAX_SAMPLES   = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;

    // Port field widths
    localparam int SAMPLE_W = 16;
    localparam int SLOPE_W  = 48;
    localparam int ICPT_W   = 64;
    localparam int COUNT_W  = 11;

    // Running sums
    localparam int LOG_N  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SX_W   = SAMPLE_BITS + LOG_N + 1;
    localparam int SXX_W  = 2 * SAMPLE_BITS + LOG_N - 1;
    localparam int SXY_W  = 2 * SAMPLE_BITS + LOG_N;

    // Solver datapath
    localparam int MA_W   = SXY_W + 2;
    localparam int MB_W   = SX_W + 1;
    localparam int P_W    = MA_W + MB_W;
    localparam int SLH_W  = SLOPE_W / 2;
    localparam int ACC_W  = SLOPE_W + SX_W + 1;
    localparam int DEN_W  = 2 * SAMPLE_BITS + 2 * LOG_N;
    localparam int DVD_W  = ACC_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(DVD_W);

    // Queue of finished data sets
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        FIT_OK       = 2'd0,
        FIT_ZERO_DEN = 2'd1,
        FIT_DROPPED  = 2'd2
    } t_fit_status;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_sample;
        logic signed [SAMPLE_W-1:0] y_sample;
        logic                       last_pair;
    } t_pair_in;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope_q16;
        logic signed [ICPT_W-1:0]  intercept_q16;
        logic [COUNT_W-1:0]        pair_count;
        t_fit_status               fit_status;
    } t_fit_out;

    // Sums of one finished data set
    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic signed [SX_W-1:0]  sx;
        logic signed [SX_W-1:0]  sy;
        logic [SXX_W-1:0]        sxx;
        logic signed [SXY_W-1:0] sxy;
        logic                    dropped;
    } t_snap;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ACC,
        BK_DIV,
        BK_FIN,
        BK_OUT
    } t_bk_state;

    // Multiply passes of the solver
    typedef enum logic [2:0] {
        OP_N_SXX,
        OP_SX_SX,
        OP_N_SXY,
        OP_SX_SY,
        OP_SLO_SX,
        OP_SHI_SX
    } t_op;

endpackage

// File: sv/lrf_accum.sv
// ============================================================================
// Linear regression fit - accumulator front end
// Takes one pair per cycle unless the queue is full, updates count and sums,
// hands a finished data set to the queue on the last pair and clears for the next set.
// ============================================================================
`include "linear_regression_fit_defines.svh"

module lrf_accum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lrf_pkg::t_pair_in i_pair,
    input  logic             i_q_full,
    output logic             o_snap_push,
    output lrf_pkg::t_snap   o_snap
);
    import lrf_pkg::*;

    logic                          accept;
    logic                          room;
    logic signed [SAMPLE_BITS-1:0] x_val;
    logic signed [SAMPLE_BITS-1:0] y_val;
    logic signed [2*SAMPLE_BITS-1:0] xx;
    logic signed [2*SAMPLE_BITS-1:0] xy;

    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic signed [SX_W-1:0]  r_sx, n_sx;
    logic signed [SX_W-1:0]  r_sy, n_sy;
    logic [SXX_W-1:0]        r_sxx, n_sxx;
    logic signed [SXY_W-1:0] r_sxy, n_sxy;
    logic                    r_drop, n_drop;

    assign accept = i_push && !i_q_full;
    assign room   = r_cnt < CNT_W'(MAX_SAMPLES);
    assign x_val  = i_pair.x_sample[SAMPLE_BITS-1:0];
    assign y_val  = i_pair.y_sample[SAMPLE_BITS-1:0];

    // Square and cross product of the incoming pair
    assign xx = x_val * x_val;
    assign xy = x_val * y_val;

    // Sum update, snapshot on the last pair, then clear
    always_comb begin
        n_cnt  = r_cnt;
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_sxx  = r_sxx;
        n_sxy  = r_sxy;
        n_drop = r_drop;
        if (accept && room) begin
            n_cnt = r_cnt + 1'b1;
            n_sx  = r_sx + SX_W'(x_val);
            n_sy  = r_sy + SX_W'(y_val);
            n_sxx = r_sxx + SXX_W'($unsigned(xx));
            n_sxy = r_sxy + SXY_W'(xy);
        end
        if (accept && !room) begin
            n_drop = 1'b1;
        end

        o_snap.cnt     = n_cnt;
        o_snap.sx      = n_sx;
        o_snap.sy      = n_sy;
        o_snap.sxx     = n_sxx;
        o_snap.sxy     = n_sxy;
        o_snap.dropped = n_drop;
        o_snap_push    = accept && i_pair.last_pair;

        if (o_snap_push) begin
            n_cnt  = '0;
            n_sx   = '0;
            n_sy   = '0;
            n_sxx  = '0;
            n_sxy  = '0;
            n_drop = 1'b0;
        end
    end

    // Sum registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_sxx  <= '0;
            r_sxy  <= '0;
            r_drop <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_sxx  <= n_sxx;
            r_sxy  <= n_sxy;
            r_drop <= n_drop;
        end
    end

    // Checks
    `LRF_ASSERT_IMPL(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_SAMPLES), "count above capacity")
    `LRF_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, accept && i_pair.last_pair, r_cnt == '0 && !r_drop && r_sxx == '0, "sums not cleared after last pair")
    `LRF_ASSERT_NEXT(a_drop_sets, i_clk, i_rst_n, accept && !room && !i_pair.last_pair, r_drop && r_cnt == CNT_W'(MAX_SAMPLES), "pair beyond capacity not flagged")

endmodule

// File: sv/lrf_queue.sv
// ============================================================================
// Linear regression fit - data set queue
// Short queue of finished sums between the accumulator and the solver.
// ============================================================================
`include "linear_regression_fit_defines.svh"

module lrf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lrf_pkg::t_snap i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lrf_pkg::t_snap o_data
);
    import lrf_pkg::*;

    t_snap               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_FILL_W-1:0] r_fill, n_fill;
    logic                push_ok;
    logic                pop_ok;

    assign o_full  = r_fill == Q_FILL_W'(Q_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_data  = r_slot[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_fill = r_fill + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // Checks
    `LRF_ASSERT_IMPL(a_fill_cap, i_clk, i_rst_n, 1'b1, r_fill <= Q_FILL_W'(Q_DEPTH), "queue fill above depth")
    `LRF_ASSERT_NEXT(a_fill_inc, i_clk, i_rst_n, push_ok && !pop_ok, r_fill == $past(r_fill) + 1'b1, "fill did not grow on push")
    `LRF_ASSERT_NEXT(a_fill_dec, i_clk, i_rst_n, pop_ok && !push_ok, r_fill == $past(r_fill) - 1'b1, "fill did not shrink on pop")

endmodule

// File: sv/lrf_solver.sv
// ============================================================================
// Linear regression fit - solver back end
// Forms the denominator and numerators with one shared multiplier, runs two
// bit-serial divisions if the denominator is nonzero, saturates, and holds the result for the consumer.
// ============================================================================
`include "linear_regression_fit_defines.svh"

module lrf_solver (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  lrf_pkg::t_snap   i_snap,
    input  logic             i_pop,
    output logic             o_empty,
    output lrf_pkg::t_fit_out o_fit
);
    import lrf_pkg::*;

    localparam logic [DVD_W-1:0] SlopePos = (DVD_W'(1) << (SLOPE_W - 1)) - DVD_W'(1);
    localparam logic [DVD_W-1:0] IcptPos  = (DVD_W'(1) << (ICPT_W - 1)) - DVD_W'(1);

    t_bk_state                r_state, n_state;
    t_op                      r_op, n_op;
    t_snap                    r_snap, n_snap;
    logic signed [P_W-1:0]    r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [DEN_W-1:0]         r_den, n_den;
    logic [DEN_W-1:0]         r_rem, n_rem;
    logic [DVD_W-1:0]         r_dq, n_dq;
    logic                     r_neg, n_neg;
    logic                     r_div_slope, n_div_slope;
    logic [STEP_W-1:0]        r_step, n_step;
    logic signed [SLOPE_W-1:0] r_slope, n_slope;
    logic signed [ICPT_W-1:0] r_icpt, n_icpt;
    t_fit_status              r_status, n_status;
    t_fit_out                 r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [P_W-1:0]    mul_p;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  sy_q;
    logic signed [ACC_W-1:0]  sub_lhs;
    logic signed [ACC_W-1:0]  sub_rhs;
    logic signed [ACC_W-1:0]  acc_diff;
    logic [ACC_W-1:0]         diff_abs;
    logic                     den_bad;
    logic [DEN_W:0]           rem_sh;
    logic [DEN_W:0]           rem_diff;
    logic                     q_bit;
    logic [DVD_W-1:0]         sat_lim;
    logic [DVD_W-1:0]         sat_mag;
    logic [DVD_W-1:0]         sat_val;

    assign o_empty = !r_out_valid;
    assign o_fit   = r_out;

    // Shared multiplier operand select
    always_comb begin
        unique case (r_op)
            OP_N_SXX: begin
                mul_a = MA_W'(r_snap.sxx);
                mul_b = MB_W'(r_snap.cnt);
            end
            OP_SX_SX: begin
                mul_a = MA_W'(r_snap.sx);
                mul_b = MB_W'(r_snap.sx);
            end
            OP_N_SXY: begin
                mul_a = MA_W'(r_snap.sxy);
                mul_b = MB_W'(r_snap.cnt);
            end
            OP_SX_SY: begin
                mul_a = MA_W'(r_snap.sy);
                mul_b = MB_W'(r_snap.sx);
            end
            OP_SLO_SX: begin
                mul_a = MA_W'(r_slope[SLH_W-1:0]);
                mul_b = MB_W'(r_snap.sx);
            end
            OP_SHI_SX: begin
                mul_a = MA_W'($signed(r_slope[SLOPE_W-1:SLH_W]));
                mul_b = MB_W'(r_snap.sx);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One subtractor serves denominator, numerator and intercept terms
    assign prod_ext = ACC_W'(r_prod);
    assign sy_q     = ACC_W'(r_snap.sy) <<< FRACTION_BITS;
    assign sub_lhs  = (r_op == OP_SLO_SX) ? sy_q : r_acc;
    assign sub_rhs  = (r_op == OP_SHI_SX) ? (prod_ext <<< SLH_W) : prod_ext;
    assign acc_diff = sub_lhs - sub_rhs;
    assign diff_abs = acc_diff[ACC_W-1] ? (~acc_diff + 1'b1) : acc_diff;
    assign den_bad  = acc_diff[ACC_W-1] || (acc_diff == '0) || (r_snap.cnt == '0);

    // Restoring division step
    assign rem_sh   = {r_rem, r_dq[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign q_bit    = !rem_diff[DEN_W];

    // Saturation of the finished quotient
    assign sat_lim = (r_div_slope ? SlopePos : IcptPos) + DVD_W'(r_neg);
    assign sat_mag = (r_dq > sat_lim) ? sat_lim : r_dq;
    assign sat_val = r_neg ? (~sat_mag + 1'b1) : sat_mag;

    // Sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_snap      = r_snap;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_den       = r_den;
        n_rem       = r_rem;
        n_dq        = r_dq;
        n_neg       = r_neg;
        n_div_slope = r_div_slope;
        n_step      = r_step;
        n_slope     = r_slope;
        n_icpt      = r_icpt;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_q_pop     = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_snap  = i_snap;
                    n_op    = OP_N_SXX;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_prod  = mul_p;
                n_state = BK_ACC;
            end
            BK_ACC: begin
                unique case (r_op)
                    OP_N_SXX: begin
                        n_acc   = prod_ext;
                        n_op    = OP_SX_SX;
                        n_state = BK_MUL;
                    end
                    OP_SX_SX: begin
                        if (den_bad) begin
                            n_slope  = '0;
                            n_icpt   = '0;
                            n_status = FIT_ZERO_DEN;
                            n_state  = BK_OUT;
                        end else begin
                            n_den   = acc_diff[DEN_W-1:0];
                            n_op    = OP_N_SXY;
                            n_state = BK_MUL;
                        end
                    end
                    OP_N_SXY: begin
                        n_acc   = prod_ext;
                        n_op    = OP_SX_SY;
                        n_state = BK_MUL;
                    end
                    OP_SX_SY: begin
                        // slope = |num| * 2^F / D
                        n_neg       = acc_diff[ACC_W-1];
                        n_dq        = {diff_abs, FRACTION_BITS'(0)};
                        n_rem       = '0;
                        n_step      = STEP_W'(DVD_W - 1);
                        n_div_slope = 1'b1;
                        n_state     = BK_DIV;
                    end
                    OP_SLO_SX: begin
                        n_acc   = acc_diff;
                        n_op    = OP_SHI_SX;
                        n_state = BK_MUL;
                    end
                    OP_SHI_SX: begin
                        // intercept = |Sy*2^F - slope*Sx| / n
                        n_neg       = acc_diff[ACC_W-1];
                        n_dq        = DVD_W'(diff_abs);
                        n_den       = DEN_W'(r_snap.cnt);
                        n_rem       = '0;
                        n_step      = STEP_W'(DVD_W - 1);
                        n_div_slope = 1'b0;
                        n_state     = BK_DIV;
                    end
                    default: begin
                        n_state = BK_IDLE;
                    end
                endcase
            end
            BK_DIV: begin
                n_rem = q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                n_dq  = {r_dq[DVD_W-2:0], q_bit};
                if (r_step == '0) begin
                    n_state = BK_FIN;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            BK_FIN: begin
                if (r_div_slope) begin
                    n_slope = sat_val[SLOPE_W-1:0];
                    n_op    = OP_SLO_SX;
                    n_state = BK_MUL;
                end else begin
                    n_icpt   = sat_val[ICPT_W-1:0];
                    n_status = r_snap.dropped ? FIT_DROPPED : FIT_OK;
                    n_state  = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_out.slope_q16     = r_slope;
                    n_out.intercept_q16 = r_icpt;
                    n_out.pair_count    = COUNT_W'(r_snap.cnt);
                    n_out.fit_status    = r_status;
                    n_out_valid         = 1'b1;
                    n_state             = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_snap      <= n_snap;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_den       <= n_den;
        r_rem       <= n_rem;
        r_dq        <= n_dq;
        r_neg       <= n_neg;
        r_div_slope <= n_div_slope;
        r_step      <= n_step;
        r_slope     <= n_slope;
        r_icpt      <= n_icpt;
        r_status    <= n_status;
        r_out       <= n_out;
    end

    // Checks
    `LRF_ASSERT_IMPL(a_zero_den_out, i_clk, i_rst_n, r_out_valid && r_out.fit_status == FIT_ZERO_DEN, r_out.slope_q16 == '0 && r_out.intercept_q16 == '0, "zero denominator with nonzero fit")
    `LRF_ASSERT_IMPL(a_div_den, i_clk, i_rst_n, r_state == BK_DIV, r_den != '0, "division by zero")
    `LRF_ASSERT_NEXT(a_div_step, i_clk, i_rst_n, r_state == BK_DIV && r_step != '0, r_state == BK_DIV && r_step == $past(r_step) - 1'b1, "division step count broken")
    `LRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_state == BK_OUT && r_out_valid && !i_pop, r_state == BK_OUT, "result lost while output busy")

endmodule

// File: sv/linear_regression_fit.sv
// ============================================================================
// Linear regression fit - top level
// Streaming least-squares line fit. Pairs (x, y) are taken one per cycle
// while full is low; the running count and the sums of x, y, x*x and x*y are
// kept, and the pair marked last closes the data set. The closed set's sums
// move into a two-entry queue, and the accumulator starts over in the very
// next cycle. The solver takes one set from that queue and emits its result
// after six passes through one shared 44x28 multiplier, two restoring
// divisions at one quotient bit per cycle (92 bits each), and the saturation
// steps; a zero-denominator set goes to the output after the first two passes.
// full rises only when two closed sets wait on the solver, so pairs keep
// flowing at one per cycle as long as the solver keeps up with the closed
// sets. Results wait in an output register until popped. Pairs beyond
// capacity are counted out and flagged in the status of their set.
// ============================================================================
`include "linear_regression_fit_defines.svh"

module linear_regression_fit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  lrf_pkg::t_pair_in i_pair,
    output logic              empty,
    input  logic              pop,
    output lrf_pkg::t_fit_out o_fit
);
    import lrf_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_snap acc_snap;
    t_snap q_snap;

    assign full = q_full;

    // Front end: sums per data set
    lrf_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pair      (i_pair),
        .i_q_full    (q_full),
        .o_snap_push (q_push),
        .o_snap      (acc_snap)
    );

    // Closed data sets waiting for the solver
    lrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (acc_snap),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_snap)
    );

    // Back end: slope and intercept
    lrf_solver u_solver (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_snap    (q_snap),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_fit     (o_fit)
    );

    // Checks
    `LRF_ASSERT_IMPL(a_full_blocks, i_clk, i_rst_n, full, !q_push, "set closed into a full queue")
    `LRF_ASSERT_NEXT(a_last_queued, i_clk, i_rst_n, push && !full && i_pair.last_pair, !q_empty, "closed set not queued")
    `LRF_ASSERT_IMPL(a_pop_needs_set, i_clk, i_rst_n, q_pop, !q_empty, "solver popped an empty queue")

endmodule

// File: verif/tb_linear_regression_fit.sv
`timescale 1ns / 1ps
// ============================================================================
// Line-fit block - self-checking testbench
// Streams (x, y) pairs into the block through its push/full side and pops fit
// results from its empty/pop side, with random gaps on both sides. A local
// least-squares calculator tracks the running sums and predicts each fit on
// wide signed vectors. A short table of hand-picked data sets comes first.
// It is followed by random data sets of mixed shape and one set that runs
// past capacity.
// ============================================================================
module tb_linear_regression_fit;
    import lrf_pkg::*;

    // Width of the exact fit arithmetic
    localparam int WIDE = 192;
    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_PAIRS = 800;

    typedef enum int {
        X_WIDE,
        X_NARROW,
        X_FIXED,
        X_TWO
    } t_x_spread;

    typedef struct packed {
        t_pair_in pair;
        logic     has_fit;
        t_fit_out fit;
    } t_plan_row;

    // Hand-picked data sets; a fit is typed in only where it is obvious
    localparam t_plan_row DIRECTED [DIRECTED_ROWS] = '{
        // single pair: no spread in x
        '{'{16'sd5, -16'sd7, 1'b1}, 1'b1, '{48'sd0, 64'sd0, 11'd1, FIT_ZERO_DEN}},
        // two pairs at the same extreme x
        '{'{16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, '0},
        '{'{16'sh8000, 16'sh8000, 1'b1}, 1'b1, '{48'sd0, 64'sd0, 11'd2, FIT_ZERO_DEN}},
        // corner to corner, rising
        '{'{16'sh8000, 16'sh8000, 1'b0}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh7FFF, 1'b1}, 1'b1, '{48'sd65536, 64'sd0, 11'd2, FIT_OK}},
        // corner to corner, falling
        '{'{16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh8000, 1'b1}, 1'b1,
          '{-48'sd65536, -64'sd65536, 11'd2, FIT_OK}},
        // steepest slope: full y swing over one step of x
        '{'{16'sd0, 16'sh8000, 1'b0}, 1'b0, '0},
        '{'{16'sd1, 16'sh7FFF, 1'b1}, 1'b1,
          '{48'sd4294901760, -64'sd2147483648, 11'd2, FIT_OK}},
        // negative fractional slope, truncated toward zero
        '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, '0},
        '{'{16'sd3, -16'sd1, 1'b1}, 1'b0, '0},
        // three scattered pairs
        '{'{-16'sd1, 16'sd2, 1'b0}, 1'b0, '0},
        '{'{16'sd0, -16'sd5, 1'b0}, 1'b0, '0},
        '{'{16'sd4, 16'sd7, 1'b1}, 1'b0, '0},
        // x all zero, y at its extremes
        '{'{16'sd0, 16'sd1, 1'b0}, 1'b0, '0},
        '{'{16'sd0, 16'sh8000, 1'b0}, 1'b0, '0},
        '{'{16'sd0, 16'sh7FFF, 1'b1}, 1'b1, '{48'sd0, 64'sd0, 11'd3, FIT_ZERO_DEN}},
        // flat line at zero
        '{'{16'sh7FFF, 16'sd0, 1'b0}, 1'b0, '0},
        '{'{-16'sd1, 16'sd0, 1'b1}, 1'b1, '{48'sd0, 64'sd0, 11'd2, FIT_OK}},
        // uneven pairs
        '{'{16'sd100, -16'sd200, 1'b0}, 1'b0, '0},
        '{'{-16'sd7, 16'sd13, 1'b0}, 1'b0, '0},
        '{'{16'sd12345, -16'sd23456, 1'b1}, 1'b0, '0}
    };

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     push;
    logic     full;
    t_pair_in i_pair;
    logic     empty;
    logic     pop;
    t_fit_out o_fit;

    // Running sums of the open data set
    int       run_count = 0;
    longint   run_sx = 0;
    longint   run_sy = 0;
    longint   run_sxx = 0;
    longint   run_sxy = 0;
    bit       run_dropped = 1'b0;

    t_fit_out fit_expected[$];
    int       error_count = 0;
    int       pairs_sent = 0;
    int       sets_closed = 0;
    int       fits_checked = 0;
    int       zero_den_fits = 0;
    int       dropped_fits = 0;
    int       send_zero_run = 0;
    int       recv_zero_run = 0;

    linear_regression_fit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_pair  (i_pair),
        .empty   (empty),
        .pop     (pop),
        .o_fit   (o_fit)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idle cycles before the next item; sometimes a long run with none
    function automatic int draw_wait(inout int zero_run);
        if (zero_run > 0) begin
            zero_run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            zero_run = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic signed [WIDE-1:0] clamp_signed(
        input logic signed [WIDE-1:0] v,
        input int bits
    );
        logic signed [WIDE-1:0] top;
        top = WIDE'(1);
        top = top <<< (bits - 1);
        if (v >= top)
            return top - 1;
        if (v < -top)
            return -top;
        return v;
    endfunction

    // Add one pair to the open set; on the last pair, solve the fit and clear
    function automatic bit accumulate_pair(input t_pair_in p, output t_fit_out fit);
        logic signed [WIDE-1:0] n_w, sx_w, sy_w, sxx_w, sxy_w, den, num, slope_w, icpt_w;
        fit = '0;
        if (run_count < MAX_SAMPLES) begin
            run_count++;
            run_sx += longint'(p.x_sample);
            run_sy += longint'(p.y_sample);
            run_sxx += longint'(p.x_sample) * longint'(p.x_sample);
            run_sxy += longint'(p.x_sample) * longint'(p.y_sample);
        end else begin
            run_dropped = 1'b1;
        end
        if (!p.last_pair)
            return 1'b0;

        n_w = WIDE'(run_count);
        sx_w = WIDE'(run_sx);
        sy_w = WIDE'(run_sy);
        sxx_w = WIDE'(run_sxx);
        sxy_w = WIDE'(run_sxy);
        den = n_w * sxx_w - sx_w * sx_w;
        if (den <= 0) begin
            fit.fit_status = FIT_ZERO_DEN;
        end else begin
            num = n_w * sxy_w - sx_w * sy_w;
            slope_w = clamp_signed((num <<< FRACTION_BITS) / den, SLOPE_W);
            // intercept uses the slope after saturation
            icpt_w = clamp_signed(((sy_w <<< FRACTION_BITS) - slope_w * sx_w) / n_w, ICPT_W);
            fit.slope_q16 = slope_w[SLOPE_W-1:0];
            fit.intercept_q16 = icpt_w[ICPT_W-1:0];
            fit.fit_status = run_dropped ? FIT_DROPPED : FIT_OK;
        end
        fit.pair_count = run_count[COUNT_W-1:0];

        run_count = 0;
        run_sx = 0;
        run_sy = 0;
        run_sxx = 0;
        run_sxy = 0;
        run_dropped = 1'b0;
        return 1'b1;
    endfunction

    // Push one pair after a random gap; record its fit once it is taken
    task automatic drive_pair(input t_pair_in p, input bit has_fit, input t_fit_out typed_fit);
        int gap;
        t_fit_out fit;
        gap = draw_wait(send_zero_run);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pair <= p;
        do @(posedge i_clk); while (full);
        pairs_sent++;
        if (accumulate_pair(p, fit)) begin
            sets_closed++;
            fit_expected = {fit_expected, (has_fit ? typed_fit : fit)};
        end
    endtask

    // One data set of random pairs with the given spread of x
    task automatic run_data_set(input int len, input t_x_spread spread);
        t_pair_in p;
        logic [SAMPLE_W-1:0] x_base, x_other;
        bit y_wide;
        x_base = 16'($urandom);
        x_other = 16'($urandom);
        y_wide = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++) begin
            case (spread)
                X_WIDE: p.x_sample = 16'($urandom);
                X_NARROW: p.x_sample = 16'($urandom_range(0, 40)) - 16'd20;
                X_FIXED: p.x_sample = x_base;
                default: p.x_sample = $urandom_range(0, 1) ? x_base : x_other;
            endcase
            p.y_sample = y_wide ? 16'($urandom) : 16'($urandom_range(0, 200)) - 16'd100;
            p.last_pair = (k == len - 1);
            drive_pair(p, 1'b0, '0);
        end
    endtask

    // Hold off new pairs until every pending fit has come out
    task automatic settle_fits();
        push <= 1'b0;
        do @(posedge i_clk); while (fit_expected.size() != 0);
    endtask

    // Stimulus
    initial begin : stimulus
        int small_pairs;
        int len;
        int pick;
        bit wide_cap_done;
        t_x_spread spread;
        small_pairs = 0;
        wide_cap_done = 1'b0;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_pair <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            drive_pair(DIRECTED[r].pair, DIRECTED[r].has_fit, DIRECTED[r].fit);
        settle_fits();

        while (small_pairs < RANDOM_PAIRS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            spread = (pick < 4) ? X_WIDE : (pick < 7) ? X_NARROW :
                     (pick == 7) ? X_FIXED : X_TWO;
            run_data_set(len, spread);
            small_pairs += len;
            // past capacity once, with spread x
            if (!wide_cap_done && small_pairs >= 250) begin
                run_data_set(MAX_SAMPLES + 2, X_WIDE);
                wide_cap_done = 1'b1;
            end
            if ($urandom_range(0, 24) == 0)
                settle_fits();
        end
        push <= 1'b0;

        while (fit_expected.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Sent %0d pairs in %0d data sets; checked %0d fits", pairs_sent,
                 sets_closed, fits_checked);
        $display("Fits with zero denominator: %0d, with dropped pairs: %0d",
                 zero_den_fits, dropped_fits);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Result side: pop after random stalls and compare with the oldest fit
    initial begin : fit_sink
        int gap;
        t_fit_out want;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_wait(recv_zero_run);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            fits_checked++;
            if (fit_expected.size() == 0) begin
                $error("fit result popped with no fit pending");
                error_count++;
            end else begin
                want = fit_expected.pop_front();
                if (want.fit_status == FIT_ZERO_DEN)
                    zero_den_fits++;
                if (want.fit_status == FIT_DROPPED)
                    dropped_fits++;
                if (o_fit.slope_q16 !== want.slope_q16) begin
                    $error("slope_q16: expected %0d, got %0d", want.slope_q16, o_fit.slope_q16);
                    error_count++;
                end
                if (o_fit.intercept_q16 !== want.intercept_q16) begin
                    $error("intercept_q16: expected %0d, got %0d",
                           want.intercept_q16, o_fit.intercept_q16);
                    error_count++;
                end
                if (o_fit.pair_count !== want.pair_count) begin
                    $error("pair_count: expected %0d, got %0d", want.pair_count,
                           o_fit.pair_count);
                    error_count++;
                end
                if (o_fit.fit_status !== want.fit_status) begin
                    $error("fit_status: expected %0d, got %0d", want.fit_status,
                           o_fit.fit_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout with %0d fits still pending", fit_expected.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
